// ===== sv/lspd_pkg.sv =====
package lspd_pkg;

  localparam int unsigned PeakW     = 15;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned DurW      = 22;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 22;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 24;

  localparam logic [PeakW-1:0] PeakMax       = 15'd32767;
  localparam logic [TimeW-1:0] CheckPeriodMs = 32'd100;
  localparam logic [TimeW-1:0] FirstSilentMs = 32'd1500;
  localparam int unsigned      WideShift     = 16;

  localparam logic [PeakW-1:0] ThresholdRst = 15'd300;
  localparam logic [DurW-1:0]  DebounceRst  = 22'd1000;
  localparam logic [DurW-1:0]  SilenceRst   = 22'd300000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENSE_ENABLE    = 3'd0,
    CFG_WIDE_SAMPLES    = 3'd1,
    CFG_LEVEL_THRESHOLD = 3'd2,
    CFG_DEBOUNCE_MS     = 3'd3,
    CFG_SILENCE_MS      = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_PRESENT = 2'd1,
    EVT_ABSENT  = 2'd2
  } report_event_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_e;

  typedef struct packed {
    logic [PeakW-1:0] checked_peak;
    report_event_e    report_event;
    logic             state_reported;
    logic             signal_present;
    logic             evaluated;
  } result_t;

  // Magnitude of a 16-bit two's complement value, saturated to the peak range.
  function automatic logic [PeakW-1:0] magnitude16(input logic [15:0] h);
    logic [15:0] neg;
    logic [PeakW-1:0] m;
    neg = ~h + 16'd1;
    if (!h[15]) begin
      m = h[PeakW-1:0];
    end else if (neg[15]) begin
      m = PeakMax;
    end else begin
      m = neg[PeakW-1:0];
    end
    return m;
  endfunction

endpackage

// ===== sv/line_signal_presence_detector.sv =====
// A result passes through the input register and then the result register. Throughput: one
// item per cycle while the result stream is not stalled; the peak and timer update between the
// two registers is combinational.
// Reset (rst_ni low, asynchronous) clears the peak, timers and flags and loads the
// register defaults: sensing on, 16-bit samples, threshold 300, 1000 ms, 300000 ms.
module line_signal_presence_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lspd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lspd_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: sample_value [31:0], now_ms [63:32]
  input  logic [lspd_pkg::InDataW-1:0]     s_axis_tdata_i,
  // tuser: func [0]
  input  logic                             s_axis_tuser_i,
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: evaluated [0], signal_present [1], state_reported [2],
  //        report_event [4:3], checked_peak [19:5], zero [23:20]
  output logic [lspd_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  // Configuration registers.
  logic                          sense_enable_q;
  logic                          wide_samples_q;
  logic [lspd_pkg::PeakW-1:0]    level_threshold_q;
  logic [lspd_pkg::DurW-1:0]     debounce_ms_q;
  logic [lspd_pkg::DurW-1:0]     silence_ms_q;

  // Input stage.
  logic                          in_valid_q;
  logic                          in_func_q;
  logic [lspd_pkg::SampleW-1:0]  in_sample_q;
  logic [lspd_pkg::TimeW-1:0]    in_now_q;

  // Detector state.
  logic [lspd_pkg::PeakW-1:0]    peak_accum_q, peak_accum_d;
  logic [lspd_pkg::TimeW-1:0]    last_check_q, last_check_d;
  logic [lspd_pkg::TimeW-1:0]    above_since_q, above_since_d;
  logic [lspd_pkg::TimeW-1:0]    below_since_q, below_since_d;
  logic                          present_q, present_d;
  logic                          reported_q, reported_d;
  logic [lspd_pkg::PeakW-1:0]    held_peak_q, held_peak_d;

  // Result register.
  logic                          out_valid_q;
  lspd_pkg::result_t             out_q, out_d;

  logic                          advance;
  logic                          in_accept;
  logic [lspd_pkg::PeakW-1:0]    mag;
  logic [lspd_pkg::TimeW-1:0]    since_check;
  logic [lspd_pkg::TimeW-1:0]    since_above;
  logic [lspd_pkg::TimeW-1:0]    since_below;
  logic [lspd_pkg::TimeW-1:0]    silence_limit;
  lspd_pkg::report_event_e       event_d;
  logic                          evaluated_d;

  assign cfg_ready_o     = 1'b1;
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_enable_q    <= 1'b1;
      wide_samples_q    <= 1'b0;
      level_threshold_q <= lspd_pkg::ThresholdRst;
      debounce_ms_q     <= lspd_pkg::DebounceRst;
      silence_ms_q      <= lspd_pkg::SilenceRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lspd_pkg::CFG_SENSE_ENABLE:    sense_enable_q    <= cfg_data_i[0];
        lspd_pkg::CFG_WIDE_SAMPLES:    wide_samples_q    <= cfg_data_i[0];
        lspd_pkg::CFG_LEVEL_THRESHOLD: level_threshold_q <= cfg_data_i[lspd_pkg::PeakW-1:0];
        lspd_pkg::CFG_DEBOUNCE_MS:     debounce_ms_q     <= cfg_data_i;
        lspd_pkg::CFG_SILENCE_MS:      silence_ms_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_func_q   <= s_axis_tuser_i;
      in_sample_q <= s_axis_tdata_i[lspd_pkg::SampleW-1:0];
      in_now_q    <= s_axis_tdata_i[lspd_pkg::InDataW-1:lspd_pkg::SampleW];
    end
  end

  always_comb begin
    mag = wide_samples_q
        ? lspd_pkg::magnitude16(in_sample_q[lspd_pkg::WideShift +: 16])
        : lspd_pkg::magnitude16(in_sample_q[15:0]);
    since_check   = in_now_q - last_check_q;
    since_above   = in_now_q - above_since_q;
    since_below   = in_now_q - below_since_q;
    silence_limit = reported_q ? {{(lspd_pkg::TimeW-lspd_pkg::DurW){1'b0}}, silence_ms_q}
                               : lspd_pkg::FirstSilentMs;

    peak_accum_d  = peak_accum_q;
    last_check_d  = last_check_q;
    above_since_d = above_since_q;
    below_since_d = below_since_q;
    present_d     = present_q;
    reported_d    = reported_q;
    held_peak_d   = held_peak_q;
    evaluated_d   = 1'b0;
    event_d       = lspd_pkg::EVT_NONE;

    if (in_func_q == lspd_pkg::FUNC_SAMPLE) begin
      if (sense_enable_q && (mag > peak_accum_q)) begin
        peak_accum_d = mag;
      end
    end else if (sense_enable_q && (since_check >= lspd_pkg::CheckPeriodMs)) begin
      last_check_d = in_now_q;
      peak_accum_d = '0;
      held_peak_d  = peak_accum_q;
      evaluated_d  = 1'b1;
      if (peak_accum_q >= level_threshold_q) begin
        below_since_d = '0;
        if (!present_q) begin
          if (above_since_q == '0) begin
            above_since_d = in_now_q;
          end else if (since_above >=
                       {{(lspd_pkg::TimeW-lspd_pkg::DurW){1'b0}}, debounce_ms_q}) begin
            present_d  = 1'b1;
            reported_d = 1'b1;
            event_d    = lspd_pkg::EVT_PRESENT;
          end
        end
      end else begin
        above_since_d = '0;
        // Silence only counts while present, or before anything has been reported.
        if (present_q || !reported_q) begin
          if (below_since_q == '0) begin
            below_since_d = in_now_q;
          end else if (since_below >= silence_limit) begin
            present_d  = 1'b0;
            reported_d = 1'b1;
            event_d    = lspd_pkg::EVT_ABSENT;
          end
        end
      end
    end

    out_d.evaluated      = evaluated_d;
    out_d.signal_present = present_d;
    out_d.state_reported = reported_d;
    out_d.report_event   = event_d;
    out_d.checked_peak   = held_peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_accum_q  <= '0;
      last_check_q  <= '0;
      above_since_q <= '0;
      below_since_q <= '0;
      present_q     <= 1'b0;
      reported_q    <= 1'b0;
      held_peak_q   <= '0;
      out_valid_q   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        peak_accum_q  <= peak_accum_d;
        last_check_q  <= last_check_d;
        above_since_q <= above_since_d;
        below_since_q <= below_since_d;
        present_q     <= present_d;
        reported_q    <= reported_d;
        held_peak_q   <= held_peak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lspd_pkg::OutDataW-$bits(lspd_pkg::result_t)){1'b0}}, out_q};

endmodule
